// ===== hdl/mtkx_pkg.sv =====
// Shared types, constants and ALU operation codes for the MT19937 keystream XOR core.
package mtkx_pkg;

  // Twister table geometry
  localparam int TBL_N     = 624;
  localparam int TBL_M     = 397;
  localparam int TBL_SPLIT = 227;
  localparam int IDX_W     = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  // Index constants at table width
  localparam idx_t IDX_LAST  = idx_t'(TBL_N - 1);
  localparam idx_t IDX_N     = idx_t'(TBL_N);
  localparam idx_t IDX_M     = idx_t'(TBL_M);
  localparam idx_t IDX_SPLIT = idx_t'(TBL_SPLIT);

  // Generator constants
  localparam word_t MAG_MATRIX = 32'h9908_b0df;
  localparam word_t INIT_MULT  = 32'h6c07_8965;
  localparam word_t TEMPER_B   = 32'h9d2c_5680;
  localparam word_t TEMPER_C   = 32'hefc6_0000;

  // Command codes on the input channel
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  // Shared unit operations
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_INIT   = 2'd0;
  localparam alu_op_t ALU_MIX    = 2'd1;
  localparam alu_op_t ALU_TEMPER = 2'd2;

  // Request to the shared unit
  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
    word_t   c;
    idx_t    k;
  } alu_req_t;

endpackage

// ===== hdl/mtkx_if.sv =====
// Valid/ready channel interfaces for the request and result sides.
interface mtkx_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] seed;
  logic [7:0]  data_byte;
  logic        last_byte;

  modport source (output valid, command, seed, data_byte, last_byte, input ready);
  modport sink   (input valid, command, seed, data_byte, last_byte, output ready);
endinterface

interface mtkx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       last_out;

  modport source (output valid, plain_byte, last_out, input ready);
  modport sink   (input valid, plain_byte, last_out, output ready);
endinterface

// ===== hdl/mtkx_table.sv =====
// Twister table memory: one write port, two registered read ports.
module mtkx_table (
  input  logic           clk,
  input  logic           we,
  input  mtkx_pkg::idx_t waddr,
  input  mtkx_pkg::word_t wdata,
  input  logic           re_a,
  input  mtkx_pkg::idx_t raddr_a,
  output mtkx_pkg::word_t rdata_a,
  input  logic           re_b,
  input  mtkx_pkg::idx_t raddr_b,
  output mtkx_pkg::word_t rdata_b
);

  mtkx_pkg::word_t mem [mtkx_pkg::TBL_N];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two entries, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/mtkx_alu.sv =====
// Shared generator unit: seed step, twist mix and tempering, result registered.
module mtkx_alu (
  input  logic               clk,
  input  mtkx_pkg::alu_req_t req,
  output mtkx_pkg::word_t    y
);

  mtkx_pkg::word_t y_next;
  mtkx_pkg::word_t fold;
  mtkx_pkg::word_t joined;
  mtkx_pkg::word_t mixed;
  mtkx_pkg::word_t t1;
  mtkx_pkg::word_t t2;
  mtkx_pkg::word_t t3;

  // Seed step: k + mult * (p ^ p >> 30)
  assign fold = req.a ^ (req.a >> 30);

  // Twist mix of upper bit, lower bits and far entry
  assign joined = {req.a[31], req.b[30:0]};
  assign mixed  = (joined >> 1) ^ (req.b[0] ? mtkx_pkg::MAG_MATRIX : 32'h0) ^ req.c;

  // Tempering chain
  assign t1 = req.a ^ (req.a >> 11);
  assign t2 = t1 ^ ((t1 << 7) & mtkx_pkg::TEMPER_B);
  assign t3 = t2 ^ ((t2 << 15) & mtkx_pkg::TEMPER_C);

  always_comb begin
    unique case (req.op)
      mtkx_pkg::ALU_INIT:   y_next = (fold * mtkx_pkg::INIT_MULT) + {22'b0, req.k};
      mtkx_pkg::ALU_MIX:    y_next = mixed;
      mtkx_pkg::ALU_TEMPER: y_next = t3 ^ (t3 >> 18);
      default:              y_next = req.a;
    endcase
  end

  // Register the result
  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

// ===== hdl/mt19937_keystream_xor_core.sv =====
// Top level: sequencer for seeding, twisting and keystream XOR over one table.
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   command, seed, data_byte, last_byte
//   res_ch    out  valid/ready   plain_byte, last_out
//
// A restart request writes the seed on acceptance, then the walk fills each further entry
// through the shared multiplier in INIT_MUL and INIT_WR. A data request goes through
// table read, temper and key to its result; one in every 624 first adds a twist,
// a priming read and then read, mix and write-back for each entry.
// Before any restart a data request goes straight to the done state and passes the byte as is.
// Synchronous reset clears the sequencer; the table holds nothing until seeded.
// A stalled result waits in the output register while the next request is taken.
module mt19937_keystream_xor_core (
  input  logic            clk,
  input  logic            rst,
  mtkx_in_if.sink         req_ch,
  mtkx_out_if.source      res_ch
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT_MUL = 4'd1;
  localparam logic [3:0] ST_INIT_WR  = 4'd2;
  localparam logic [3:0] ST_TW_PRE   = 4'd3;
  localparam logic [3:0] ST_TW_RD    = 4'd4;
  localparam logic [3:0] ST_TW_MIX   = 4'd5;
  localparam logic [3:0] ST_TW_WR    = 4'd6;
  localparam logic [3:0] ST_RD_WORD  = 4'd7;
  localparam logic [3:0] ST_TEMPER   = 4'd8;
  localparam logic [3:0] ST_KEY      = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  logic [3:0]         state;
  logic               seeded;
  mtkx_pkg::idx_t     words_left;
  mtkx_pkg::idx_t     ptr;
  mtkx_pkg::idx_t     k;
  logic               out_valid;

  mtkx_pkg::word_t    p;
  mtkx_pkg::word_t    cur;
  logic [7:0]         data_q;
  logic               last_q;
  logic [7:0]         key;
  logic [7:0]         plain_q;
  logic               last_out_q;

  logic               in_fire;
  logic               out_free;
  mtkx_pkg::idx_t     wl_dec;
  mtkx_pkg::idx_t     ptr_eff;
  mtkx_pkg::idx_t     k_succ;
  mtkx_pkg::idx_t     far_addr;

  logic               we;
  mtkx_pkg::idx_t     waddr;
  mtkx_pkg::word_t    wdata;
  logic               re_a;
  mtkx_pkg::idx_t     raddr_a;
  mtkx_pkg::word_t    rdata_a;
  logic               re_b;
  mtkx_pkg::word_t    rdata_b;
  mtkx_pkg::alu_req_t alu_req;
  mtkx_pkg::word_t    alu_y;

  assign req_ch.ready      = (state == ST_IDLE);
  assign in_fire           = req_ch.valid && req_ch.ready;
  assign out_free          = !out_valid || res_ch.ready;
  assign res_ch.valid      = out_valid;
  assign res_ch.plain_byte = plain_q;
  assign res_ch.last_out   = last_out_q;

  // Address helpers
  assign wl_dec   = words_left - mtkx_pkg::idx_t'(1);
  assign ptr_eff  = (ptr >= mtkx_pkg::IDX_N) ? '0 : ptr;
  assign k_succ   = (k == mtkx_pkg::IDX_LAST) ? '0 : k + mtkx_pkg::idx_t'(1);
  assign far_addr = (k < mtkx_pkg::IDX_SPLIT) ? k + mtkx_pkg::IDX_M : k - mtkx_pkg::IDX_SPLIT;

  // Table write port
  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = alu_y;
    unique case (state)
      ST_IDLE: begin
        we    = in_fire && (req_ch.command == mtkx_pkg::CMD_RESTART);
        waddr = '0;
        wdata = req_ch.seed;
      end
      ST_INIT_WR, ST_TW_WR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Table read ports
  always_comb begin
    re_a    = 1'b0;
    raddr_a = k_succ;
    re_b    = 1'b0;
    unique case (state)
      ST_TW_PRE: begin
        re_a    = 1'b1;
        raddr_a = '0;
      end
      ST_TW_RD: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      ST_RD_WORD: begin
        re_a    = 1'b1;
        raddr_a = ptr_eff;
      end
      default: begin
        re_a = 1'b0;
      end
    endcase
  end

  // Shared unit request
  always_comb begin
    alu_req.op = mtkx_pkg::ALU_TEMPER;
    alu_req.a  = rdata_a;
    alu_req.b  = rdata_a;
    alu_req.c  = rdata_b;
    alu_req.k  = k;
    unique case (state)
      ST_INIT_MUL: begin
        alu_req.op = mtkx_pkg::ALU_INIT;
        alu_req.a  = p;
      end
      ST_TW_MIX: begin
        alu_req.op = mtkx_pkg::ALU_MIX;
        alu_req.a  = cur;
      end
      default: begin
        alu_req.op = mtkx_pkg::ALU_TEMPER;
      end
    endcase
  end

  mtkx_table u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (far_addr),
    .rdata_b (rdata_b)
  );

  mtkx_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .y   (alu_y)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seeded     <= 1'b0;
      words_left <= mtkx_pkg::idx_t'(1);
      ptr        <= '0;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise the result from the done state, drop it once taken
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && res_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (req_ch.command == mtkx_pkg::CMD_RESTART) begin
              k     <= mtkx_pkg::idx_t'(1);
              state <= ST_INIT_MUL;
            end else if (!seeded) begin
              state <= ST_DONE;
            end else if (wl_dec == '0) begin
              words_left <= mtkx_pkg::IDX_N;
              ptr        <= '0;
              k          <= '0;
              state      <= ST_TW_PRE;
            end else begin
              words_left <= wl_dec;
              state      <= ST_RD_WORD;
            end
          end
        end
        ST_INIT_MUL: begin
          state <= ST_INIT_WR;
        end
        ST_INIT_WR: begin
          if (k == mtkx_pkg::IDX_LAST) begin
            seeded     <= 1'b1;
            words_left <= mtkx_pkg::idx_t'(1);
            ptr        <= '0;
            state      <= ST_IDLE;
          end else begin
            k     <= k + mtkx_pkg::idx_t'(1);
            state <= ST_INIT_MUL;
          end
        end
        ST_TW_PRE: begin
          state <= ST_TW_RD;
        end
        ST_TW_RD: begin
          state <= ST_TW_MIX;
        end
        ST_TW_MIX: begin
          state <= ST_TW_WR;
        end
        ST_TW_WR: begin
          if (k == mtkx_pkg::IDX_LAST) begin
            state <= ST_RD_WORD;
          end else begin
            k     <= k + mtkx_pkg::idx_t'(1);
            state <= ST_TW_RD;
          end
        end
        ST_RD_WORD: begin
          ptr   <= ptr_eff + mtkx_pkg::idx_t'(1);
          state <= ST_TEMPER;
        end
        ST_TEMPER: begin
          state <= ST_KEY;
        end
        ST_KEY: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_fire) begin
      p      <= req_ch.seed;
      data_q <= req_ch.data_byte;
      last_q <= req_ch.last_byte;
      key    <= '0;
    end
    if (state == ST_INIT_WR) begin
      p <= alu_y;
    end
    // Carry the old value of the current entry
    if (state == ST_TW_RD) begin
      cur <= rdata_a;
    end
    if (state == ST_KEY) begin
      key <= alu_y[8:1];
    end
    if ((state == ST_DONE) && out_free) begin
      plain_q    <= data_q ^ key;
      last_out_q <= last_q;
    end
  end

`ifndef SYNTH
  // Table is written only by the seed walk, the twist or a restart request
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_IDLE) || (state == ST_INIT_WR) || (state == ST_TW_WR))
    else $error("table written outside seed or twist");

  // Read pointer never exceeds the table size
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= mtkx_pkg::IDX_N)
    else $error("read pointer beyond table");

  // Word count stays in range once seeded
  a_words_left: assert property (@(posedge clk) disable iff (rst)
    seeded |-> (words_left != '0) && (words_left <= mtkx_pkg::IDX_N))
    else $error("words left out of range");

  // A result appears only from the done state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");
`endif

endmodule
